// ===== hw/rtl/lth_pkg.sv =====
package lth_pkg;

  localparam int ERR_W   = 14;
  localparam int EXT_W   = 11;
  localparam int GRID_W  = 11;
  localparam int PROBE_W = 10;
  localparam int DIST_W  = 7;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 11;

  localparam logic [GRID_W-1:0] GRID_MAX = 11'd1024;
  localparam logic [DIST_W-1:0] DIST_MIN = 7'd1;
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MAIN   = 2'd1;
  localparam logic [1:0] PH_MINOR  = 2'd2;
  localparam logic [1:0] PH_BASE   = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [GRID_W-1:0] width_eff;
    logic [GRID_W-1:0] height_eff;
  } cfg_t;

  typedef struct packed {
    logic               is_final;
    logic [PROBE_W-1:0] probe_x;
    logic [PROBE_W-1:0] probe_y;
    logic [DIST_W-1:0]  hit_distance;
    logic [PIX_W-1:0]   hit_pixel;
  } res_t;

endpackage

// ===== hw/rtl/lth_stage.sv =====
module lth_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

endmodule

// ===== hw/rtl/lth_walker.sv =====
module lth_walker #(
  parameter int COORD_BITS = 12,
  parameter int ITEM_W     = 2 * COORD_BITS + 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lth_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  logic [ITEM_W-1:0]  item,
  input  logic               res_ready,
  output logic               res_valid,
  output lth_pkg::res_t      res
);

  localparam int CB   = COORD_BITS;
  localparam int CW   = CB + 1;
  localparam int PW   = CB + 3;
  localparam int DW   = PW + 1;
  localparam int CMPW = (PW > lth_pkg::GRID_W) ? PW : lth_pkg::GRID_W;
  localparam int EW   = lth_pkg::ERR_W;
  localparam int XW   = lth_pkg::EXT_W;

  localparam int O_BY   = CB;
  localparam int O_SX   = 2 * CB;
  localparam int O_SY   = O_SX + 2;
  localparam int O_DX   = O_SY + 2;
  localparam int O_DY   = O_DX + XW;
  localparam int O_AX   = O_DY + XW;
  localparam int O_CNT  = O_AX + 1;
  localparam int O_PIX  = O_CNT + lth_pkg::CNT_W;
  localparam int O_COND = O_PIX + lth_pkg::PIX_W;
  localparam int O_OP   = ITEM_W - 1;

  logic signed [CB-1:0]   in_bx, in_by;
  logic signed [1:0]      in_sx, in_sy;
  logic [XW-1:0]          in_dx, in_dy;
  logic                   in_axis, in_cond, in_op;
  logic [lth_pkg::CNT_W-1:0] in_cnt;
  logic [lth_pkg::PIX_W-1:0] in_pix;

  assign in_bx   = item[CB-1:0];
  assign in_by   = item[O_BY+CB-1:O_BY];
  assign in_sx   = item[O_SX+1:O_SX];
  assign in_sy   = item[O_SY+1:O_SY];
  assign in_dx   = item[O_DX+XW-1:O_DX];
  assign in_dy   = item[O_DY+XW-1:O_DY];
  assign in_axis = item[O_AX];
  assign in_cnt  = item[O_CNT+lth_pkg::CNT_W-1:O_CNT];
  assign in_pix  = item[O_PIX+lth_pkg::PIX_W-1:O_PIX];
  assign in_cond = item[O_COND];
  assign in_op   = item[O_OP];

  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [EW-1:0] err_acc_r, err_acc_nxt, err_prev_r, err_prev_nxt;
  logic [lth_pkg::CNT_W-1:0] iter_r, iter_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic signed [1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [XW-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic                 axis_r, axis_nxt, mode_r, mode_nxt;
  logic signed [CB-1:0] spx_r, spx_nxt, spy_r, spy_nxt;

  function automatic logic signed [PW-1:0] cell_coord(input logic signed [CW-1:0] c,
                                                      input logic signed [1:0] s,
                                                      input logic back);
    logic signed [PW-1:0] v;
    v = PW'(c);
    if (back) begin
      v = v - PW'(s);
    end
    return v;
  endfunction

  function automatic logic [DW-1:0] abs_diff(input logic signed [PW-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  logic fire;
  assign fire      = item_valid && res_ready;
  assign res_valid = item_valid;

  // Cell of the outstanding probe, for the distance of a hit.
  logic signed [PW-1:0] hit_x, hit_y;
  logic [DW:0]          hit_sum;
  logic [lth_pkg::DIST_W-1:0] hit_dist;

  always_comb begin
    hit_x = cell_coord(cur_x_r, sx_r, (phase_r == lth_pkg::PH_MINOR && !axis_r) ||
                                      (phase_r == lth_pkg::PH_BASE && axis_r));
    hit_y = cell_coord(cur_y_r, sy_r, (phase_r == lth_pkg::PH_MINOR && axis_r) ||
                                      (phase_r == lth_pkg::PH_BASE && !axis_r));
    hit_sum = (DW + 1)'(abs_diff(hit_x, spx_r)) + (DW + 1)'(abs_diff(hit_y, spy_r));
    if (hit_sum == '0) begin
      hit_dist = lth_pkg::DIST_MIN;
    end else if (hit_sum > (DW + 1)'(lth_pkg::DIST_MAX)) begin
      hit_dist = lth_pkg::DIST_MAX;
    end else begin
      hit_dist = hit_sum[lth_pkg::DIST_W-1:0];
    end
  end

  logic [XW-1:0]        dmaj, dmin;
  logic [XW:0]          dmaj2, dmin2;
  logic signed [EW-1:0] acc1, acc2;
  logic signed [EW:0]   sum_cur, sum_new;
  logic                 do_req;
  logic [1:0]           req_ph;
  logic [lth_pkg::DIST_W-1:0] fin_dist;
  logic [lth_pkg::PIX_W-1:0]  fin_pix;
  logic signed [PW-1:0] req_x, req_y;
  logic                 req_in, req_ok;

  always_comb begin
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    err_acc_nxt  = err_acc_r;
    err_prev_nxt = err_prev_r;
    iter_nxt     = iter_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    axis_nxt     = axis_r;
    mode_nxt     = mode_r;
    spx_nxt      = spx_r;
    spy_nxt      = spy_r;
    do_req       = 1'b0;
    req_ph       = lth_pkg::PH_MAIN;
    fin_dist     = '0;
    fin_pix      = '0;

    dmaj    = axis_r ? dx_r : dy_r;
    dmin    = axis_r ? dy_r : dx_r;
    dmaj2   = {dmaj, 1'b0};
    dmin2   = {dmin, 1'b0};
    acc1    = '0;
    acc2    = '0;
    sum_cur = (EW + 1)'(err_acc_r) + (EW + 1)'(err_prev_r);
    sum_new = '0;

    if (in_op == lth_pkg::OP_START) begin
      spx_nxt   = in_bx;
      spy_nxt   = in_by;
      sx_nxt    = in_sx;
      sy_nxt    = in_sy;
      dx_nxt    = in_dx;
      dy_nxt    = in_dy;
      axis_nxt  = in_axis;
      iter_nxt  = in_cnt;
      mode_nxt  = cfg.mode;
      cur_x_nxt = CW'(in_bx);
      cur_y_nxt = CW'(in_by);
      if (cfg.mode) begin
        err_acc_nxt = EW'(in_axis ? in_dx : in_dy);
      end else begin
        err_acc_nxt = '0;
      end
      err_prev_nxt = err_acc_nxt;
      do_req       = cfg.mode || (in_cnt != '0);
    end else if (phase_r == lth_pkg::PH_IDLE) begin
      do_req = 1'b0;
    end else if (in_cond) begin
      fin_dist = hit_dist;
      fin_pix  = in_pix;
    end else if (!mode_r) begin
      acc1 = err_acc_r + EW'(dmin);
      err_acc_nxt = acc1;
      if ($signed({acc1, 1'b0}) >= $signed((EW + 1)'(dmaj))) begin
        err_acc_nxt = acc1 - EW'(dmaj);
        if (axis_r) begin
          cur_y_nxt = cur_y_r + CW'(sy_r);
        end else begin
          cur_x_nxt = cur_x_r + CW'(sx_r);
        end
      end
      if (axis_r) begin
        cur_x_nxt = cur_x_r + CW'(sx_r);
      end else begin
        cur_y_nxt = cur_y_r + CW'(sy_r);
      end
      iter_nxt = iter_r - 1'b1;
      do_req   = (iter_nxt != '0);
    end else if (phase_r == lth_pkg::PH_MINOR) begin
      do_req = 1'b1;
      req_ph = (sum_cur == $signed((EW + 1)'(dmaj2))) ? lth_pkg::PH_BASE : lth_pkg::PH_MAIN;
    end else if (phase_r == lth_pkg::PH_BASE) begin
      do_req = 1'b1;
    end else begin
      err_prev_nxt = err_acc_r;
      if (iter_r != '0) begin
        do_req   = 1'b1;
        iter_nxt = iter_r - 1'b1;
        if (axis_r) begin
          cur_x_nxt = cur_x_r + CW'(sx_r);
        end else begin
          cur_y_nxt = cur_y_r + CW'(sy_r);
        end
        acc1 = err_acc_r + EW'(dmin2);
        err_acc_nxt = acc1;
        if ((EW + 1)'(acc1) > $signed((EW + 1)'(dmaj2))) begin
          if (axis_r) begin
            cur_y_nxt = cur_y_r + CW'(sy_r);
          end else begin
            cur_x_nxt = cur_x_r + CW'(sx_r);
          end
          acc2 = acc1 - EW'(dmaj2);
          err_acc_nxt = acc2;
          sum_new = (EW + 1)'(acc2) + (EW + 1)'(err_acc_r);
          req_ph = (sum_new > $signed((EW + 1)'(dmaj2))) ? lth_pkg::PH_BASE
                                                         : lth_pkg::PH_MINOR;
        end
      end
    end

    req_x = cell_coord(cur_x_nxt, sx_nxt, (req_ph == lth_pkg::PH_MINOR && !axis_nxt) ||
                                          (req_ph == lth_pkg::PH_BASE && axis_nxt));
    req_y = cell_coord(cur_y_nxt, sy_nxt, (req_ph == lth_pkg::PH_MINOR && axis_nxt) ||
                                          (req_ph == lth_pkg::PH_BASE && !axis_nxt));
    req_in = !req_x[PW-1] && !req_y[PW-1] &&
             (CMPW'(unsigned'(req_x)) < CMPW'(cfg.width_eff)) &&
             (CMPW'(unsigned'(req_y)) < CMPW'(cfg.height_eff));
    req_ok = do_req && req_in;

    phase_nxt = req_ok ? req_ph : lth_pkg::PH_IDLE;

    res.is_final     = !req_ok;
    res.probe_x      = req_ok ? lth_pkg::PROBE_W'(req_x) : '0;
    res.probe_y      = req_ok ? lth_pkg::PROBE_W'(req_y) : '0;
    res.hit_distance = req_ok ? '0 : fin_dist;
    res.hit_pixel    = req_ok ? '0 : fin_pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lth_pkg::PH_IDLE;
      mode_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      err_acc_r  <= err_acc_nxt;
      err_prev_r <= err_prev_nxt;
      iter_r     <= iter_nxt;
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      axis_r     <= axis_nxt;
      spx_r      <= spx_nxt;
      spy_r      <= spy_nxt;
    end
  end

endmodule

// ===== hw/rtl/line_trace_first_hit.sv =====
// A request goes from the input register through the walker to the output register.
// Throughput: one request per cycle while the output is not stalled; the input and
// output registers each hold one request, and the walk state updates once per step.
// Reset (synchronous, rst_n low) empties both registers, returns the walker to idle,
// and sets trace_mode to 0 and grid width and height to 1024.
module line_trace_first_hit #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // begin_x, begin_y, step_x, step_y, delta_x, delta_y, major_is_x, step_count,
  // pixel_value, condition_met, then zero fill
  input  logic [((2*COORD_BITS+47+7)/8)*8-1:0] in_tdata,
  // opcode
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // probe_x, probe_y, hit_distance, hit_pixel, then zero fill
  output logic [39:0]                  out_tdata,
  // is_final
  output logic                         out_tuser,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [10:0]                  cfg_wdata
);

  localparam int IN_DW  = ((2 * COORD_BITS + 47 + 7) / 8) * 8;
  localparam int ITEM_W = IN_DW + 1;
  localparam int RES_W  = $bits(lth_pkg::res_t);

  logic        mode_r;
  logic [10:0] width_r, height_r;
  lth_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= lth_pkg::GRID_MAX;
      height_r <= lth_pkg::GRID_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        lth_pkg::REG_MODE:   mode_r   <= cfg_wdata[0];
        lth_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        lth_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.mode       = mode_r;
  assign cfg.width_eff  = (width_r > lth_pkg::GRID_MAX) ? lth_pkg::GRID_MAX : width_r;
  assign cfg.height_eff = (height_r > lth_pkg::GRID_MAX) ? lth_pkg::GRID_MAX : height_r;

  logic              item_valid, res_ready, res_valid;
  logic [ITEM_W-1:0] item;
  lth_pkg::res_t     res, res_q;

  lth_stage #(.W(ITEM_W)) u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  ({in_tuser, in_tdata}),
    .m_valid (item_valid),
    .m_ready (res_ready),
    .m_data  (item)
  );

  lth_walker #(.COORD_BITS(COORD_BITS), .ITEM_W(ITEM_W)) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  lth_stage #(.W(RES_W)) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (res_q)
  );

  assign out_tuser = res_q.is_final;
  assign out_tdata = {5'b0, res_q.hit_pixel, res_q.hit_distance, res_q.probe_y, res_q.probe_x};

endmodule

// ===== hw/rtl/lth_checker.sv =====
module lth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_final_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[19:0] == 20'd0)
    else $error("final report carries probe coordinates");

  a_probe_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[39:20] == 20'd0)
    else $error("probe request carries report fields");

  a_miss_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[26:20] == 7'd0 |-> out_tdata[34:27] == 8'd0)
    else $error("report without hit carries a pixel");

endmodule

bind line_trace_first_hit lth_checker u_lth_checker (.*);

// ===== sim/tb_line_trace_first_hit.sv =====
module tb_line_trace_first_hit;

  localparam int COORD_BITS = 12;
  localparam int TDATA_W = ((2*COORD_BITS+47+7)/8)*8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                          opcode;
    logic [COORD_BITS-1:0]         begin_x;
    logic [COORD_BITS-1:0]         begin_y;
    logic [1:0]                    step_x;
    logic [1:0]                    step_y;
    logic [lth_pkg::EXT_W-1:0]     delta_x;
    logic [lth_pkg::EXT_W-1:0]     delta_y;
    logic                          major_is_x;
    logic [lth_pkg::CNT_W-1:0]     step_count;
    logic [lth_pkg::PIX_W-1:0]     pixel_value;
    logic                          condition_met;
  } trace_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [39:0]        out_tdata;
  logic               out_tuser;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = lth_pkg::REG_MODE;
  logic [10:0]        cfg_wdata = '0;

  // Copy of the register file.
  logic                       grid_mode = 1'b0;
  logic [lth_pkg::GRID_W-1:0] grid_cols = lth_pkg::GRID_MAX;
  logic [lth_pkg::GRID_W-1:0] grid_rows = lth_pkg::GRID_MAX;

  // Walker state mirrored from the block.
  int                        walk_x = 0;
  int                        walk_y = 0;
  int                        err_now = 0;
  int                        err_last = 0;
  logic [lth_pkg::CNT_W-1:0] steps_left = '0;
  logic [1:0]                walk_phase = lth_pkg::PH_IDLE;
  int                        dir_x = 0;
  int                        dir_y = 0;
  int                        ext_x = 0;
  int                        ext_y = 0;
  logic                      x_major = 1'b0;
  logic                      cover_mode = 1'b0;
  int                        origin_x = 0;
  int                        origin_y = 0;

  lth_pkg::res_t pending_replies[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int   hold_count = 0;

  line_trace_first_hit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_trace_first_hit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_count <= 0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!hold_req) hold_count <= 0;
    end
  end

  always @(posedge clk) begin : check_replies
    lth_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected: is_final %0d, tdata %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.is_final) begin
          $error("is_final: expected %0d, actual %0d", want.is_final, out_tuser);
          mismatches++;
        end
        if (out_tdata[9:0] !== want.probe_x) begin
          $error("probe_x: expected %0d, actual %0d", want.probe_x, out_tdata[9:0]);
          mismatches++;
        end
        if (out_tdata[19:10] !== want.probe_y) begin
          $error("probe_y: expected %0d, actual %0d", want.probe_y, out_tdata[19:10]);
          mismatches++;
        end
        if (out_tdata[26:20] !== want.hit_distance) begin
          $error("hit_distance: expected %0d, actual %0d", want.hit_distance,
                 out_tdata[26:20]);
          mismatches++;
        end
        if (out_tdata[34:27] !== want.hit_pixel) begin
          $error("hit_pixel: expected %0d, actual %0d", want.hit_pixel, out_tdata[34:27]);
          mismatches++;
        end
      end
    end
  end

  function automatic int wrap_coord(input int v);
    logic signed [COORD_BITS:0] t;
    t = v[COORD_BITS:0];
    return t;
  endfunction

  function automatic int wrap_err(input int v);
    logic signed [lth_pkg::ERR_W-1:0] t;
    t = v[lth_pkg::ERR_W-1:0];
    return t;
  endfunction

  function automatic int usable(input logic [lth_pkg::GRID_W-1:0] v);
    return (v > lth_pkg::GRID_MAX) ? lth_pkg::GRID_MAX : v;
  endfunction

  function automatic logic in_grid(input int x, input int y);
    return x >= 0 && x < usable(grid_cols) && y >= 0 && y < usable(grid_rows);
  endfunction

  function automatic lth_pkg::res_t report(input logic [lth_pkg::DIST_W-1:0] span,
                                           input logic [lth_pkg::PIX_W-1:0] pix);
    lth_pkg::res_t r;
    r = '0;
    r.is_final = 1'b1;
    r.hit_distance = span;
    r.hit_pixel = pix;
    walk_phase = lth_pkg::PH_IDLE;
    return r;
  endfunction

  function automatic void locate(input logic [1:0] ph, output int x, output int y);
    x = walk_x;
    y = walk_y;
    if (ph == lth_pkg::PH_MINOR) begin
      if (x_major) y = walk_y - dir_y;
      else x = walk_x - dir_x;
    end else if (ph == lth_pkg::PH_BASE) begin
      if (x_major) x = walk_x - dir_x;
      else y = walk_y - dir_y;
    end
  endfunction

  function automatic lth_pkg::res_t probe(input logic [1:0] ph);
    lth_pkg::res_t r;
    int x, y;
    locate(ph, x, y);
    if (!in_grid(x, y)) return report('0, '0);
    walk_phase = ph;
    r = '0;
    r.probe_x = x[lth_pkg::PROBE_W-1:0];
    r.probe_y = y[lth_pkg::PROBE_W-1:0];
    return r;
  endfunction

  function automatic lth_pkg::res_t walk_reply(input trace_item_t it);
    int x, y, span, maj2, min2;
    if (it.opcode == lth_pkg::OP_START) begin
      origin_x = $signed(it.begin_x);
      origin_y = $signed(it.begin_y);
      dir_x = $signed(it.step_x);
      dir_y = $signed(it.step_y);
      ext_x = it.delta_x;
      ext_y = it.delta_y;
      x_major = it.major_is_x;
      steps_left = it.step_count;
      cover_mode = grid_mode;
      walk_x = wrap_coord(origin_x);
      walk_y = wrap_coord(origin_y);
      if (cover_mode) begin
        err_now = wrap_err(x_major ? ext_x : ext_y);
      end else begin
        err_now = 0;
        if (steps_left == 0) return report('0, '0);
      end
      err_last = err_now;
      return probe(lth_pkg::PH_MAIN);
    end

    if (walk_phase == lth_pkg::PH_IDLE) return report('0, '0);

    if (it.condition_met) begin
      locate(walk_phase, x, y);
      span = (x > origin_x ? x - origin_x : origin_x - x) +
             (y > origin_y ? y - origin_y : origin_y - y);
      if (span < lth_pkg::DIST_MIN) span = lth_pkg::DIST_MIN;
      if (span > lth_pkg::DIST_MAX) span = lth_pkg::DIST_MAX;
      return report(span[lth_pkg::DIST_W-1:0], it.pixel_value);
    end

    if (!cover_mode) begin
      if (x_major) begin
        err_now = wrap_err(err_now + ext_y);
        if (2 * err_now >= ext_x) begin
          walk_y = wrap_coord(walk_y + dir_y);
          err_now = wrap_err(err_now - ext_x);
        end
        walk_x = wrap_coord(walk_x + dir_x);
      end else begin
        err_now = wrap_err(err_now + ext_x);
        if (2 * err_now >= ext_y) begin
          walk_x = wrap_coord(walk_x + dir_x);
          err_now = wrap_err(err_now - ext_y);
        end
        walk_y = wrap_coord(walk_y + dir_y);
      end
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) return report('0, '0);
      return probe(lth_pkg::PH_MAIN);
    end

    maj2 = 2 * (x_major ? ext_x : ext_y);
    min2 = 2 * (x_major ? ext_y : ext_x);
    if (walk_phase == lth_pkg::PH_MINOR)
      return probe((err_now + err_last == maj2) ? lth_pkg::PH_BASE : lth_pkg::PH_MAIN);
    if (walk_phase == lth_pkg::PH_BASE) return probe(lth_pkg::PH_MAIN);

    err_last = err_now;
    if (steps_left == 0) return report('0, '0);
    steps_left = steps_left - 1'b1;
    if (x_major) walk_x = wrap_coord(walk_x + dir_x);
    else walk_y = wrap_coord(walk_y + dir_y);
    err_now = wrap_err(err_now + min2);
    if (err_now > maj2) begin
      if (x_major) walk_y = wrap_coord(walk_y + dir_y);
      else walk_x = wrap_coord(walk_x + dir_x);
      err_now = wrap_err(err_now - maj2);
      return probe((err_now + err_last > maj2) ? lth_pkg::PH_BASE : lth_pkg::PH_MINOR);
    end
    return probe(lth_pkg::PH_MAIN);
  endfunction

  function automatic trace_item_t noise_item();
    trace_item_t it;
    it.opcode = 1'($urandom);
    it.begin_x = COORD_BITS'($urandom);
    it.begin_y = COORD_BITS'($urandom);
    it.step_x = 2'($urandom);
    it.step_y = 2'($urandom);
    it.delta_x = lth_pkg::EXT_W'($urandom);
    it.delta_y = lth_pkg::EXT_W'($urandom);
    it.major_is_x = 1'($urandom);
    it.step_count = lth_pkg::CNT_W'($urandom);
    it.pixel_value = lth_pkg::PIX_W'($urandom);
    it.condition_met = 1'($urandom);
    return it;
  endfunction

  function automatic trace_item_t answer_item(input logic met);
    trace_item_t it;
    it = noise_item();
    it.opcode = lth_pkg::OP_ANSWER;
    it.condition_met = met;
    return it;
  endfunction

  function automatic trace_item_t start_item(input int bx, input int by, input logic [1:0] sx,
                                             input logic [1:0] sy, input int dx, input int dy,
                                             input logic maj, input int cnt);
    trace_item_t it;
    it = noise_item();
    it.opcode = lth_pkg::OP_START;
    it.begin_x = bx[COORD_BITS-1:0];
    it.begin_y = by[COORD_BITS-1:0];
    it.step_x = sx;
    it.step_y = sy;
    it.delta_x = dx[lth_pkg::EXT_W-1:0];
    it.delta_y = dy[lth_pkg::EXT_W-1:0];
    it.major_is_x = maj;
    it.step_count = cnt[lth_pkg::CNT_W-1:0];
    return it;
  endfunction

  function automatic logic [1:0] pick_dir();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 2'b01;
    if (roll < 80) return 2'b11;
    if (roll < 94) return 2'b00;
    return 2'b10;
  endfunction

  function automatic trace_item_t random_line();
    trace_item_t it;
    int roll, major_ext;
    it = noise_item();
    it.opcode = lth_pkg::OP_START;
    if ($urandom_range(99) < 90) begin
      it.begin_x = COORD_BITS'($urandom_range(0, usable(grid_cols)));
      it.begin_y = COORD_BITS'($urandom_range(0, usable(grid_rows)));
    end
    it.step_x = pick_dir();
    it.step_y = pick_dir();
    roll = $urandom_range(99);
    if (roll < 75) begin
      it.delta_x = lth_pkg::EXT_W'($urandom_range(0, 40));
      it.delta_y = lth_pkg::EXT_W'($urandom_range(0, 40));
      if ($urandom_range(99) < 85) it.major_is_x = (it.delta_x >= it.delta_y);
    end else if (roll < 88) begin
      // The minor extent dwarfs the major one, so the error terms wrap.
      if (it.major_is_x) begin
        it.delta_x = lth_pkg::EXT_W'($urandom_range(0, 3));
        it.delta_y = lth_pkg::EXT_W'($urandom_range(1000, 2047));
      end else begin
        it.delta_y = lth_pkg::EXT_W'($urandom_range(0, 3));
        it.delta_x = lth_pkg::EXT_W'($urandom_range(1000, 2047));
      end
    end
    major_ext = it.major_is_x ? it.delta_x : it.delta_y;
    roll = $urandom_range(99);
    if (roll < 65) it.step_count = lth_pkg::CNT_W'($urandom_range(0, 20));
    else if (roll < 90) it.step_count = lth_pkg::CNT_W'(major_ext + 1);
    return it;
  endfunction

  function automatic logic [lth_pkg::GRID_W-1:0] pick_size();
    case ($urandom_range(19))
      0: return 11'd1;
      1: return 11'd2;
      2, 3: return lth_pkg::GRID_MAX;
      4: return lth_pkg::GRID_W'($urandom_range(1025, 2046));
      5: return 11'd2047;
      6: return 11'd0;
      7, 8: return lth_pkg::GRID_W'($urandom_range(3, 40));
      default: return lth_pkg::GRID_W'($urandom_range(41, 1023));
    endcase
  endfunction

  task automatic offer_item(input trace_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.opcode;
    in_tdata <= {it.condition_met, it.pixel_value, it.step_count, it.major_is_x,
                 it.delta_y, it.delta_x, it.step_y, it.step_x, it.begin_y, it.begin_x};
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(walk_reply(it));
    items_sent++;
  endtask

  task automatic answer_walk(input int hit_after, input int abandon_at);
    int n;
    n = 0;
    while (walk_phase != lth_pkg::PH_IDLE && n != abandon_at) begin
      offer_item(answer_item(n == hit_after));
      n++;
    end
  endtask

  task automatic configure(input logic mode, input logic [lth_pkg::GRID_W-1:0] cols,
                           input logic [lth_pkg::GRID_W-1:0] rows);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lth_pkg::REG_MODE;
    cfg_wdata <= {10'd0, mode};
    @(posedge clk);
    cfg_index <= lth_pkg::REG_WIDTH;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= lth_pkg::REG_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_mode = mode;
    grid_cols = cols;
    grid_rows = rows;
  endtask

  task automatic test_plain_directed();
    offer_item(answer_item(1'b1));
    offer_item(start_item(0, 0, 2'b01, 2'b01, 5, 2, 1'b1, 4));
    answer_walk(2, -1);
    offer_item(start_item(3, 3, 2'b01, 2'b11, 4, 4, 1'b0, 0));
    offer_item(start_item(-2048, 2047, 2'b01, 2'b01, 1, 1, 1'b1, 3));
    offer_item(start_item(1023, 1023, 2'b01, 2'b00, 3, 0, 1'b1, 5));
    answer_walk(9, -1);
    // This line is left after one answer, and the next one replaces it while still being walked.
    offer_item(start_item(10, 10, 2'b01, 2'b01, 6, 1, 1'b1, 6));
    answer_walk(9, 1);
    offer_item(start_item(20, 20, 2'b11, 2'b11, 2, 7, 1'b0, 3));
    answer_walk(9, -1);
  endtask

  task automatic test_supercover_directed();
    configure(1'b1, 11'd2047, lth_pkg::GRID_MAX);
    offer_item(start_item(100, 100, 2'b01, 2'b01, 2, 2, 1'b1, 3));
    answer_walk(5, -1);
    offer_item(start_item(50, 50, 2'b10, 2'b01, 4, 3, 1'b1, 3));
    answer_walk(4, -1);
    offer_item(start_item(7, 9, 2'b11, 2'b01, 3, 8, 1'b0, 0));
    answer_walk(9, -1);
  endtask

  task automatic test_empty_grid();
    configure(1'b0, 11'd0, 11'd1);
    offer_item(start_item(0, 0, 2'b01, 2'b01, 1, 1, 1'b1, 2));
    offer_item(answer_item(1'b0));
  endtask

  task automatic test_distance_clamp();
    configure(1'b0, lth_pkg::GRID_MAX, lth_pkg::GRID_MAX);
    offer_item(start_item(300, 300, 2'b01, 2'b01, 10, 10, 1'b1, 400));
    answer_walk(140, -1);
  endtask

  task automatic test_output_stall();
    int saved;
    configure(1'b1, lth_pkg::GRID_MAX, lth_pkg::GRID_MAX);
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_req <= 1'b1;
    offer_item(start_item(500, 500, 2'b01, 2'b11, 9, 4, 1'b1, 30));
    answer_walk(20, -1);
    while (hold_count < HOLD_CYCLES) @(posedge clk);
    hold_req <= 1'b0;
    send_idle_pct = saved;
  endtask

  task automatic test_random_traces(input int send_pct, input int recv_pct, input int count);
    int goal, chunk_end, hit_after, abandon_at, roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      configure(1'($urandom), pick_size(), pick_size());
      chunk_end = items_sent + $urandom_range(60, 120);
      while (items_sent < chunk_end && items_sent < goal) begin
        roll = $urandom_range(99);
        if (roll < 70) hit_after = $urandom_range(0, 12);
        else if (roll < 97) hit_after = $urandom_range(13, 60);
        else hit_after = $urandom_range(128, 150);
        abandon_at = ($urandom_range(99) < 10) ? $urandom_range(0, 6) : -1;
        offer_item(random_line());
        answer_walk(hit_after, abandon_at);
        if ($urandom_range(99) < 8) offer_item(answer_item(1'($urandom)));
      end
    end
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_directed();
    test_supercover_directed();
    test_empty_grid();
    test_distance_clamp();
    test_output_stall();
    test_random_traces(34, 62, 260);
    test_random_traces(62, 34, 260);
    test_random_traces(0, 0, 240);
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("line_trace_first_hit verification clean");
    end else begin
      $display("line_trace_first_hit verification failed");
    end
    $finish;
  end

endmodule
